[rtl/cthn_pkg.sv]
// Shared types and constants for the two-hop neighborhood block.
// Used by the front classifier, the command queue, the back engine and the top level.
package cthn_pkg;

   localparam int MAX_POINTS  = 256;
   localparam int MAX_ENTRIES = 2048;
   localparam int MAX_FOUND   = 64;

   localparam int PT_W    = $clog2(MAX_POINTS);
   localparam int RS_AW   = $clog2(MAX_POINTS + 1);
   localparam int NT_AW   = $clog2(MAX_ENTRIES);
   localparam int FD_AW   = $clog2(MAX_FOUND);
   localparam int CNT_W   = $clog2(MAX_FOUND + 1);
   localparam int OFF_W   = 12;
   localparam int NP_W    = 9;

   localparam logic [1:0] CMD_ROW   = 2'd0;
   localparam logic [1:0] CMD_ENT   = 2'd1;
   localparam logic [1:0] CMD_QUERY = 2'd2;

   localparam logic [1:0] STS_OK    = 2'd0;
   localparam logic [1:0] STS_EMPTY = 2'd1;
   localparam logic [1:0] STS_BAD   = 2'd2;
   localparam logic [1:0] STS_TRUNC = 2'd3;

   typedef struct packed {
      logic [1:0]  command;
      logic [10:0] address;
      logic [11:0] value;
   } req_type;

   typedef struct packed {
      logic [7:0] neighbour;
      logic       last;
      logic [1:0] status;
   } rsp_type;

   typedef enum logic [1:0] {
      OP_ROW,
      OP_ENT,
      OP_QUERY
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [10:0] address;
      logic [11:0] value;
   } cmd_type;

endpackage

[rtl/cthn_front.sv]
// Front classifier: decodes request transfers into queue commands.
// Depends on cthn_pkg; drops unused commands and out-of-range row writes.
module cthn_front import cthn_pkg::*; (
   input  req_type req_data,
   input  logic    req_valid,
   output logic    req_ready,
   input  logic    q_full,
   output logic    q_push,
   output cmd_type q_cmd
);

   logic keep;

   always_comb begin
      keep = 1'b0;
      q_cmd.op = OP_QUERY;
      q_cmd.address = req_data.address;
      q_cmd.value = req_data.value;
      unique case (req_data.command)
         CMD_ROW: begin
            q_cmd.op = OP_ROW;
            keep = ({21'd0, req_data.address} <= 32'(MAX_POINTS));
         end
         CMD_ENT: begin
            q_cmd.op = OP_ENT;
            keep = ({21'd0, req_data.address} < 32'(MAX_ENTRIES));
         end
         CMD_QUERY: begin
            q_cmd.op = OP_QUERY;
            keep = 1'b1;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   assign req_ready = !q_full;
   assign q_push = req_valid && !q_full && keep;

endmodule

[rtl/cthn_queue.sv]
// Two-entry command queue between the front classifier and the back engine.
// Depends on cthn_pkg for the command type.
module cthn_queue import cthn_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output logic    full,
   output logic    not_empty,
   output cmd_type head
);

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   assign full = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign head = slot_ff[rd_ptr_ff];

endmodule

[rtl/cthn_back.sv]
// Back engine: holds the graph tables, walks two-hop queries and drives results.
// Depends on cthn_pkg; takes commands from cthn_queue.
module cthn_back import cthn_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_wr_en,
   input  logic [NP_W-1:0] csr_wr_data,
   input  logic          q_not_empty,
   input  cmd_type       q_head,
   output logic          q_pop,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output rsp_type       rsp_data
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_RS_S, ST_RS_E, ST_OUT_CHK, ST_OUT_NB, ST_IN_S, ST_IN_E,
      ST_IN_CHK, ST_IN_NB, ST_EMIT_RD, ST_EMIT_PUT, ST_SINGLE
   } state_type;

   state_type        state_ff;
   logic [NP_W-1:0]  num_points_ff;
   logic [OFF_W-1:0] row_start_mem [MAX_POINTS+1];
   logic [7:0]       nt_mem [MAX_ENTRIES];
   logic [7:0]       found_mem [MAX_FOUND];
   logic [MAX_POINTS-1:0] visited_ff;
   logic [OFF_W-1:0] rs_rd_ff;
   logic [7:0]       nt_rd_ff;
   logic [7:0]       found_rd_ff;
   logic [PT_W-1:0]  p_ff;
   logic [PT_W-1:0]  jp_ff;
   logic [OFF_W-1:0] i_ff, e_ff, j_ff, je_ff;
   logic [CNT_W-1:0] count_ff, idx_ff;
   logic             trunc_ff;
   logic [1:0]       status_ff;
   logic             rsp_valid_ff;
   rsp_type          rsp_data_ff;

   logic [NP_W-1:0]  np;
   logic [RS_AW-1:0] rs_raddr;
   logic [NT_AW-1:0] nt_raddr;
   logic             slot_free;
   logic             append;
   logic [OFF_W-1:0] rs_clip;
   logic             emit_last;
   logic             rsp_load;

   assign np = (num_points_ff > NP_W'(MAX_POINTS)) ? NP_W'(MAX_POINTS) : num_points_ff;
   assign rs_clip = (rs_rd_ff > OFF_W'(MAX_ENTRIES)) ? OFF_W'(MAX_ENTRIES) : rs_rd_ff;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign q_pop = (state_ff == ST_IDLE) && q_not_empty;
   assign append = (state_ff == ST_IN_NB) && ({1'b0, nt_rd_ff} < np)
                   && (nt_rd_ff != p_ff) && !visited_ff[nt_rd_ff]
                   && (count_ff < CNT_W'(MAX_FOUND));
   assign emit_last = ((idx_ff + CNT_W'(1)) == count_ff);
   assign rsp_load = ((state_ff == ST_EMIT_PUT) || (state_ff == ST_SINGLE)) && slot_free;

   always_comb begin
      rs_raddr = q_head.address[RS_AW-1:0];
      nt_raddr = j_ff[NT_AW-1:0];
      unique case (state_ff)
         ST_RS_S:    rs_raddr = RS_AW'(p_ff) + RS_AW'(1);
         ST_OUT_NB:  rs_raddr = RS_AW'(nt_rd_ff);
         ST_IN_S:    rs_raddr = RS_AW'(jp_ff) + RS_AW'(1);
         ST_OUT_CHK: nt_raddr = i_ff[NT_AW-1:0];
         default:    rs_raddr = q_head.address[RS_AW-1:0];
      endcase
   end

   always_ff @(posedge clock) begin
      if (q_pop && q_head.op == OP_ROW) begin
         row_start_mem[q_head.address[RS_AW-1:0]] <= q_head.value;
      end
      if (q_pop && q_head.op == OP_ENT) begin
         nt_mem[q_head.address[NT_AW-1:0]] <= q_head.value[7:0];
      end
      if (append) begin
         found_mem[count_ff[FD_AW-1:0]] <= nt_rd_ff;
      end
      rs_rd_ff <= row_start_mem[rs_raddr];
      nt_rd_ff <= nt_mem[nt_raddr];
      found_rd_ff <= found_mem[idx_ff[FD_AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         num_points_ff <= NP_W'(MAX_POINTS);
         visited_ff <= '0;
         rsp_valid_ff <= 1'b0;
         count_ff <= '0;
         idx_ff <= '0;
         trunc_ff <= 1'b0;
         status_ff <= STS_OK;
      end else begin
         if (csr_wr_en) begin
            num_points_ff <= csr_wr_data;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (q_pop && q_head.op == OP_QUERY) begin
                  p_ff <= q_head.address[PT_W-1:0];
                  count_ff <= '0;
                  idx_ff <= '0;
                  trunc_ff <= 1'b0;
                  if ({1'b0, q_head.address} >= {3'd0, np}) begin
                     status_ff <= STS_BAD;
                     state_ff <= ST_SINGLE;
                  end else begin
                     state_ff <= ST_RS_S;
                  end
               end
            end
            ST_RS_S: begin
               i_ff <= rs_rd_ff;
               state_ff <= ST_RS_E;
            end
            ST_RS_E: begin
               e_ff <= rs_clip;
               state_ff <= ST_OUT_CHK;
            end
            ST_OUT_CHK: begin
               if (i_ff < e_ff) begin
                  state_ff <= ST_OUT_NB;
               end else if (count_ff == '0) begin
                  status_ff <= STS_EMPTY;
                  state_ff <= ST_SINGLE;
               end else begin
                  state_ff <= ST_EMIT_RD;
               end
            end
            ST_OUT_NB: begin
               if ({1'b0, nt_rd_ff} >= np) begin
                  i_ff <= i_ff + OFF_W'(1);
                  state_ff <= ST_OUT_CHK;
               end else begin
                  jp_ff <= nt_rd_ff;
                  state_ff <= ST_IN_S;
               end
            end
            ST_IN_S: begin
               j_ff <= rs_rd_ff;
               state_ff <= ST_IN_E;
            end
            ST_IN_E: begin
               je_ff <= rs_clip;
               state_ff <= ST_IN_CHK;
            end
            ST_IN_CHK: begin
               if (j_ff < je_ff) begin
                  state_ff <= ST_IN_NB;
               end else begin
                  i_ff <= i_ff + OFF_W'(1);
                  state_ff <= ST_OUT_CHK;
               end
            end
            ST_IN_NB: begin
               j_ff <= j_ff + OFF_W'(1);
               if (append) begin
                  visited_ff[nt_rd_ff] <= 1'b1;
                  count_ff <= count_ff + CNT_W'(1);
                  state_ff <= ST_IN_CHK;
               end else if (({1'b0, nt_rd_ff} < np) && (nt_rd_ff != p_ff)
                            && !visited_ff[nt_rd_ff]) begin
                  trunc_ff <= 1'b1;
                  state_ff <= ST_EMIT_RD;
               end else begin
                  state_ff <= ST_IN_CHK;
               end
            end
            ST_EMIT_RD: begin
               state_ff <= ST_EMIT_PUT;
            end
            ST_EMIT_PUT: begin
               if (slot_free) begin
                  rsp_data_ff.neighbour <= found_rd_ff;
                  rsp_data_ff.last <= emit_last;
                  rsp_data_ff.status <= trunc_ff ? STS_TRUNC : STS_OK;
                  visited_ff[found_rd_ff] <= 1'b0;
                  idx_ff <= idx_ff + CNT_W'(1);
                  state_ff <= emit_last ? ST_IDLE : ST_EMIT_RD;
               end
            end
            ST_SINGLE: begin
               if (slot_free) begin
                  rsp_data_ff.neighbour <= 8'd0;
                  rsp_data_ff.last <= 1'b1;
                  rsp_data_ff.status <= status_ff;
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_FOUND))
      else $error("found count above limit");

   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == STS_EMPTY || rsp_data.status == STS_BAD)
      |-> rsp_data.last && rsp_data.neighbour == 8'd0)
      else $error("status-only result malformed");

   a_marks_clear: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> visited_ff == '0)
      else $error("visited marks left set between queries");

   a_trunc_full: assert property (@(posedge clock) disable iff (reset)
      $rose(trunc_ff) |-> count_ff == CNT_W'(MAX_FOUND))
      else $error("truncation below limit");

endmodule

[rtl/csr_two_hop_neighbourhood.sv]
// Top level of the two-hop neighborhood block.
// Depends on cthn_pkg; instantiates cthn_front, cthn_queue and cthn_back.
//
// Usage: the req channel carries write-row, write-entry and query commands
// as valid/ready transfers; the rsp channel returns the results of each
// query, the final one marked with last. csr_wr_en loads num_points.
// A front classifier feeds a two-entry queue; the back engine drains it.
// Writes are applied by the back engine as it pops them and return nothing.
// A query walks each first-hop entry in turn and, when its point is in
// range, each of that point's second-hop entries, then delivers its results
// one by one; the single read port of each table keeps the walk serial.
// A bad point or an empty set returns one status-only result.
// Results pass through one output register; when rsp_ready is low the
// engine holds, while the queue keeps taking up to two commands.
// Reset clears the queue, the visited marks and sets num_points to 256;
// the tables hold no contents until written.
module csr_two_hop_neighbourhood import cthn_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_type         req_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_type         rsp_data,
   input  logic            csr_wr_en,
   input  logic [NP_W-1:0] csr_wr_data
);

   logic    q_full;
   logic    q_push;
   logic    q_pop;
   logic    q_not_empty;
   cmd_type q_cmd;
   cmd_type q_head;

   cthn_front u_front (
      .req_data  (req_data),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_cmd     (q_cmd)
   );

   cthn_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_cmd  (q_cmd),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head      (q_head)
   );

   cthn_back u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .q_not_empty (q_not_empty),
      .q_head      (q_head),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

endmodule
